>>> hw/rtl/dbrs_pkg.sv
// ----------------------------------------------------------------------------
// dbrs_pkg
// Shared types and constants of the dual bank record store: controller
// states, datapath command and status bundles, operation and status codes.
// ----------------------------------------------------------------------------
package dbrs_pkg;

    localparam logic [31:0] CHECK_KEY   = 32'h3492_7c5a;
    localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
    localparam int          STAGE_DEPTH = 512;

    localparam logic [1:0] OP_STAGE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RAWW  = 2'd2;
    localparam logic [1:0] OP_RAWR  = 2'd3;

    localparam logic [2:0] ST_STAGED    = 3'd0;
    localparam logic [2:0] ST_WRITTEN   = 3'd1;
    localparam logic [2:0] ST_UNCHANGED = 3'd2;
    localparam logic [2:0] ST_MISMATCH  = 3'd3;
    localparam logic [2:0] ST_READ_OK   = 3'd4;
    localparam logic [2:0] ST_NO_VALID  = 3'd5;
    localparam logic [2:0] ST_RAW_DONE  = 3'd6;
    localparam logic [2:0] ST_BAD_INDEX = 3'd7;

    localparam logic REG_RECORD_WORDS = 1'b0;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DEC, S_CHKLEN, S_VAL, S_VDRAIN, S_VDONE, S_RDWORD,
        S_CDEC, S_CMP, S_CDRAIN, S_CCHK, S_WCNT, S_WDAT, S_WDRAIN, S_WCHK,
        S_RESULT
    } t_state;

    typedef enum logic [2:0] {
        RD_NONE, RD_WALK, RD_WALKP1, RD_WORD, RD_RAW
    } t_rd_mode;

    typedef enum logic [2:0] {
        WR_NONE, WR_CLR, WR_RAW, WR_CNT, WR_CHK
    } t_wr_mode;

    typedef enum logic [1:0] {
        K_NONE, K_VAL, K_CMP, K_WDAT
    } t_kind;

    typedef enum logic [0:0] {
        LIM_VAL, LIM_REC
    } t_lim;

    typedef enum logic [3:0] {
        RES_STAGED, RES_WRITTEN, RES_UNCHANGED, RES_MISMATCH, RES_READ,
        RES_NOVALID, RES_RAWW, RES_RAWR, RES_BADIDX
    } t_res;

    typedef struct packed {
        logic     load;
        logic     stage_wr;
        logic     cnt_clr;
        logic     ptr_clr;
        logic     ptr_inc;
        logic     sum_clr;
        logic     sum_next;
        logic     wb_clr;
        logic     wb_set;
        logic     decide;
        logic     srd;
        t_rd_mode rd;
        t_wr_mode wr;
        t_kind    kind;
        t_lim     lim;
        logic     res_load;
        t_res     res;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       last;
        logic       cnt_ok;
        logic       rec_bad;
        logic       raw_bad;
        logic       v0;
        logic       v1;
        logic       wb;
        logic       changed;
        logic       ptr_end;
        logic       clr_end;
        logic       out_free;
    } t_sts;

endpackage

>>> hw/rtl/dbrs_ctrl.sv
// ----------------------------------------------------------------------------
// dbrs_ctrl
// Sequencer of the record store. Steps each operation through bank checks,
// compare and commit walks, and issues one command bundle per cycle.
// ----------------------------------------------------------------------------
module dbrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  dbrs_pkg::t_sts i_sts,
    output dbrs_pkg::t_cmd o_cmd
);
    import dbrs_pkg::*;

    t_state r_state, n_state;
    t_res   r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= RES_STAGED;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_DEC;
            end
            S_DEC: begin
                n_state = S_RESULT;
                case (i_sts.op)
                    OP_STAGE: begin
                        if (i_sts.last) n_state = S_CHKLEN;
                        else n_code = RES_STAGED;
                    end
                    OP_READ: begin
                        if (i_sts.rec_bad) n_code = RES_BADIDX;
                        else n_state = S_VAL;
                    end
                    OP_RAWW: begin
                        n_code = i_sts.raw_bad ? RES_BADIDX : RES_RAWW;
                    end
                    default: begin
                        n_code = i_sts.raw_bad ? RES_BADIDX : RES_RAWR;
                    end
                endcase
            end
            S_CHKLEN: begin
                if (i_sts.cnt_ok) begin
                    n_state = S_VAL;
                end else begin
                    n_state = S_RESULT;
                    n_code  = RES_MISMATCH;
                end
            end
            S_VAL: begin
                if (i_sts.ptr_end) n_state = S_VDRAIN;
            end
            S_VDRAIN: begin
                n_state = i_sts.wb ? S_VDONE : S_VAL;
            end
            S_VDONE: begin
                if (i_sts.op == OP_READ) begin
                    if (!i_sts.v0 && !i_sts.v1) begin
                        n_state = S_RESULT;
                        n_code  = RES_NOVALID;
                    end else begin
                        n_state = S_RDWORD;
                    end
                end else begin
                    n_state = S_CDEC;
                end
            end
            S_RDWORD: begin
                n_state = S_RESULT;
                n_code  = RES_READ;
            end
            S_CDEC: begin
                n_state = (i_sts.v0 && i_sts.v1) ? S_CMP : S_WCNT;
            end
            S_CMP: begin
                if (i_sts.ptr_end) n_state = S_CDRAIN;
            end
            S_CDRAIN: n_state = S_CCHK;
            S_CCHK: begin
                if (i_sts.changed) begin
                    n_state = S_WCNT;
                end else begin
                    n_state = S_RESULT;
                    n_code  = RES_UNCHANGED;
                end
            end
            S_WCNT: n_state = S_WDAT;
            S_WDAT: begin
                if (i_sts.ptr_end) n_state = S_WDRAIN;
            end
            S_WDRAIN: n_state = S_WCHK;
            S_WCHK: begin
                n_state = S_RESULT;
                n_code  = RES_WRITTEN;
            end
            S_RESULT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.rd   = RD_NONE;
        o_cmd.wr   = WR_NONE;
        o_cmd.kind = K_NONE;
        o_cmd.lim  = LIM_VAL;
        o_cmd.res  = r_code;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.wr = WR_CLR;
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_DEC: begin
                case (i_sts.op)
                    OP_STAGE: o_cmd.stage_wr = 1'b1;
                    OP_READ: begin
                        if (!i_sts.rec_bad) begin
                            o_cmd.ptr_clr = 1'b1;
                            o_cmd.sum_clr = 1'b1;
                            o_cmd.wb_clr  = 1'b1;
                        end
                    end
                    OP_RAWW: begin
                        if (!i_sts.raw_bad) o_cmd.wr = WR_RAW;
                    end
                    default: begin
                        if (!i_sts.raw_bad) o_cmd.rd = RD_RAW;
                    end
                endcase
            end
            S_CHKLEN: begin
                o_cmd.cnt_clr = 1'b1;
                if (i_sts.cnt_ok) begin
                    o_cmd.ptr_clr = 1'b1;
                    o_cmd.sum_clr = 1'b1;
                    o_cmd.wb_clr  = 1'b1;
                end
            end
            S_VAL: begin
                o_cmd.rd      = RD_WALK;
                o_cmd.kind    = K_VAL;
                o_cmd.ptr_inc = 1'b1;
                o_cmd.lim     = LIM_VAL;
            end
            S_VDRAIN: begin
                if (!i_sts.wb) begin
                    o_cmd.ptr_clr = 1'b1;
                    o_cmd.sum_clr = 1'b1;
                    o_cmd.wb_set  = 1'b1;
                end
            end
            S_VDONE:  o_cmd.decide  = 1'b1;
            S_RDWORD: o_cmd.rd      = RD_WORD;
            S_CDEC:   o_cmd.ptr_clr = 1'b1;
            S_CMP: begin
                o_cmd.rd      = RD_WALKP1;
                o_cmd.srd     = 1'b1;
                o_cmd.kind    = K_CMP;
                o_cmd.ptr_inc = 1'b1;
                o_cmd.lim     = LIM_REC;
            end
            S_WCNT: begin
                o_cmd.wr       = WR_CNT;
                o_cmd.ptr_clr  = 1'b1;
                o_cmd.sum_next = 1'b1;
            end
            S_WDAT: begin
                o_cmd.srd     = 1'b1;
                o_cmd.kind    = K_WDAT;
                o_cmd.ptr_inc = 1'b1;
                o_cmd.lim     = LIM_REC;
            end
            S_WCHK:   o_cmd.wr       = WR_CHK;
            S_RESULT: o_cmd.res_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

>>> hw/rtl/dbrs_datapath.sv
// ----------------------------------------------------------------------------
// dbrs_datapath
// Bank and staging memories, walk pointer, check sum, bank decision logic
// and the output register of the record store.
// ----------------------------------------------------------------------------
module dbrs_datapath #(
    parameter int BANK_WORDS = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dbrs_pkg::t_cmd i_cmd,
    output dbrs_pkg::t_sts o_sts,
    input  logic [8:0]     i_rec_len,
    input  logic [1:0]     i_op,
    input  logic [31:0]    i_data,
    input  logic [8:0]     i_index,
    input  logic           i_bank_sel,
    input  logic           i_last,
    input  logic           i_m_tready,
    output logic           o_m_tvalid,
    output logic [31:0]    o_word_out,
    output logic [2:0]     o_status,
    output logic           o_bank_used,
    output logic [31:0]    o_write_count
);
    import dbrs_pkg::*;

    localparam int AW  = $clog2(BANK_WORDS);
    localparam int DAW = $clog2(2 * BANK_WORDS);

    logic [31:0] r_bank_mem  [2 * BANK_WORDS];
    logic [31:0] r_stage_mem [STAGE_DEPTH];

    logic [1:0]     r_op;
    logic [31:0]    r_data;
    logic [8:0]     r_idx;
    logic           r_bsel;
    logic           r_last;
    logic [9:0]     r_scnt;
    logic [DAW-1:0] r_clr_ptr;
    logic [9:0]     r_ptr;
    logic [9:0]     r_rptr;
    t_kind          r_rkind;
    logic [31:0]    r_rdata;
    logic [31:0]    r_srdata;
    logic [31:0]    r_sum;
    logic [31:0]    r_cnt [2];
    logic [1:0]     r_valid;
    logic           r_wb;
    logic           r_changed;
    logic           r_sel;
    logic           r_tgt;
    logic [31:0]    r_next;
    logic           r_ovalid;
    logic [31:0]    r_word;
    logic [2:0]     r_status;
    logic           r_used;
    logic [31:0]    r_wcnt;

    logic [9:0]     len10;
    logic [9:0]     lim;
    logic [DAW-1:0] raddr;
    logic           we;
    logic [DAW-1:0] waddr;
    logic [31:0]    wdata;
    logic [31:0]    a0, a1, adj;
    logic           nb;
    logic           sel_d, tgt_d;
    logic [31:0]    next_d;
    logic           out_free;

    function automatic logic [DAW-1:0] f_addr(input logic b, input logic [AW-1:0] o);
        return b ? DAW'(BANK_WORDS) + DAW'(o) : DAW'(o);
    endfunction

    assign len10    = {1'b0, i_rec_len};
    assign lim      = (i_cmd.lim == LIM_VAL) ? len10 + 10'd1 : len10 - 10'd1;
    assign out_free = !r_ovalid || i_m_tready;

    always_comb begin
        case (i_cmd.rd)
            RD_WALK:   raddr = f_addr(r_wb, AW'(r_ptr));
            RD_WALKP1: raddr = f_addr(r_sel, AW'(r_ptr + 10'd1));
            RD_WORD:   raddr = f_addr(r_sel, AW'({1'b0, r_idx} + 10'd1));
            RD_RAW:    raddr = f_addr(r_bsel, AW'(r_idx));
            default:   raddr = '0;
        endcase
    end

    always_comb begin
        we    = 1'b1;
        waddr = '0;
        wdata = '0;
        if (r_rkind == K_WDAT) begin
            waddr = f_addr(r_tgt, AW'(r_rptr + 10'd1));
            wdata = r_srdata;
        end else begin
            case (i_cmd.wr)
                WR_CLR: begin
                    waddr = r_clr_ptr;
                    wdata = ALL_ONES;
                end
                WR_RAW: begin
                    waddr = f_addr(r_bsel, AW'(r_idx));
                    wdata = r_data;
                end
                WR_CNT: begin
                    waddr = f_addr(r_tgt, AW'(0));
                    wdata = r_next;
                end
                WR_CHK: begin
                    waddr = f_addr(r_tgt, AW'(len10 + 10'd1));
                    wdata = r_sum ^ CHECK_KEY;
                end
                default: we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_bank_mem[waddr] <= wdata;
        if (i_cmd.rd != RD_NONE) r_rdata <= r_bank_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stage_wr && r_scnt < 10'(STAGE_DEPTH)) r_stage_mem[r_scnt[8:0]] <= r_data;
        if (i_cmd.srd) r_srdata <= r_stage_mem[r_ptr[8:0]];
    end

    always_comb begin
        a0 = r_cnt[0];
        a1 = r_cnt[1];
        if (a0 == ALL_ONES || a1 == ALL_ONES) begin
            a0 = a0 + 32'd1;
            a1 = a1 + 32'd1;
        end
        if (a0 == ALL_ONES || a1 == ALL_ONES) begin
            a0 = a0 + 32'd1;
            a1 = a1 + 32'd1;
        end
        nb  = !(a0 > a1);
        adj = nb ? a1 : a0;
        if (!r_valid[0]) sel_d = 1'b1;
        else if (!r_valid[1]) sel_d = 1'b0;
        else sel_d = nb;
        if (!r_valid[0] && !r_valid[1]) begin
            tgt_d  = 1'b0;
            next_d = '0;
        end else if (!r_valid[0]) begin
            tgt_d  = 1'b0;
            next_d = r_cnt[1] + 32'd1;
        end else if (!r_valid[1]) begin
            tgt_d  = 1'b1;
            next_d = r_cnt[0] + 32'd1;
        end else begin
            tgt_d  = !nb;
            next_d = adj + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt    <= '0;
            r_clr_ptr <= '0;
            r_rkind   <= K_NONE;
            r_wb      <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_rkind <= i_cmd.kind;
            r_rptr  <= r_ptr;
            if (i_cmd.wr == WR_CLR) r_clr_ptr <= r_clr_ptr + DAW'(1);
            if (i_cmd.load) begin
                r_op   <= i_op;
                r_data <= i_data;
                r_idx  <= i_index;
                r_bsel <= i_bank_sel;
                r_last <= i_last;
            end
            if (i_cmd.cnt_clr) r_scnt <= '0;
            else if (i_cmd.stage_wr && r_scnt < 10'(STAGE_DEPTH)) r_scnt <= r_scnt + 10'd1;
            if (i_cmd.ptr_clr) r_ptr <= '0;
            else if (i_cmd.ptr_inc) r_ptr <= r_ptr + 10'd1;
            if (i_cmd.wb_clr) r_wb <= 1'b0;
            else if (i_cmd.wb_set) r_wb <= 1'b1;
            if (i_cmd.ptr_clr) r_changed <= 1'b0;
            else if (r_rkind == K_CMP && r_rdata != r_srdata) r_changed <= 1'b1;
            if (i_cmd.sum_clr) begin
                r_sum <= '0;
            end else if (i_cmd.sum_next) begin
                r_sum <= r_next;
            end else if (r_rkind == K_VAL && r_rptr <= len10) begin
                r_sum <= r_sum + r_rdata;
            end else if (r_rkind == K_WDAT) begin
                r_sum <= r_sum + r_srdata;
            end
            if (r_rkind == K_VAL) begin
                if (r_rptr == 10'd0) r_cnt[r_wb] <= r_rdata;
                if (r_rptr == len10 + 10'd1) r_valid[r_wb] <= (r_rdata == (r_sum ^ CHECK_KEY));
            end
            if (i_cmd.decide) begin
                r_sel  <= sel_d;
                r_tgt  <= tgt_d;
                r_next <= next_d;
            end
            if (i_cmd.res_load) begin
                r_ovalid <= 1'b1;
                r_word   <= '0;
                r_used   <= 1'b0;
                r_wcnt   <= '0;
                case (i_cmd.res)
                    RES_STAGED:  r_status <= ST_STAGED;
                    RES_WRITTEN: begin
                        r_status <= ST_WRITTEN;
                        r_used   <= r_tgt;
                        r_wcnt   <= r_next;
                    end
                    RES_UNCHANGED: begin
                        r_status <= ST_UNCHANGED;
                        r_used   <= r_sel;
                        r_wcnt   <= r_cnt[r_sel];
                    end
                    RES_MISMATCH: r_status <= ST_MISMATCH;
                    RES_READ: begin
                        r_status <= ST_READ_OK;
                        r_word   <= r_rdata;
                        r_used   <= r_sel;
                        r_wcnt   <= r_cnt[r_sel];
                    end
                    RES_NOVALID: r_status <= ST_NO_VALID;
                    RES_RAWW: begin
                        r_status <= ST_RAW_DONE;
                        r_used   <= r_bsel;
                    end
                    RES_RAWR: begin
                        r_status <= ST_RAW_DONE;
                        r_word   <= r_rdata;
                        r_used   <= r_bsel;
                    end
                    default: r_status <= ST_BAD_INDEX;
                endcase
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.op       = r_op;
        o_sts.last     = r_last;
        o_sts.cnt_ok   = (r_scnt == len10);
        o_sts.rec_bad  = (r_idx >= i_rec_len);
        o_sts.raw_bad  = ({23'd0, r_idx} >= 32'(BANK_WORDS));
        o_sts.v0       = r_valid[0];
        o_sts.v1       = r_valid[1];
        o_sts.wb       = r_wb;
        o_sts.changed  = r_changed;
        o_sts.ptr_end  = (r_ptr == lim);
        o_sts.clr_end  = (r_clr_ptr == DAW'(2 * BANK_WORDS - 1));
        o_sts.out_free = out_free;
    end

    assign o_m_tvalid    = r_ovalid;
    assign o_word_out    = r_word;
    assign o_status      = r_status;
    assign o_bank_used   = r_used;
    assign o_write_count = r_wcnt;

endmodule

>>> hw/rtl/dual_bank_record_store.sv
// ----------------------------------------------------------------------------
// dual_bank_record_store
// Ping-pong storage of one checked record in two erased banks, with record
// staging, commit, record read and raw bank access.
// ----------------------------------------------------------------------------
// Record reads and commits walk the bank memory port one word a cycle, so
// their duration grows with n, the record length. One transaction is worked
// on at a time; the next one is accepted in the cycle after the result is
// registered. After reset a clearing pass erases both banks; nothing is
// accepted until it ends.
module dual_bank_record_store #(
    parameter int BANK_WORDS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // data[31:0], index[40:32], zero fill
    input  logic        i_s_tlast,
    input  logic [2:0]  i_s_tuser,   // op[1:0], bank_sel[2]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // word_out[31:0], write_count[63:32]
    output logic [3:0]  o_m_tuser    // status[2:0], bank_used[3]
);
    import dbrs_pkg::*;

    localparam int LEN_LIMIT = BANK_WORDS - 2;

    logic [8:0]  r_record_words;
    logic [8:0]  rec_len;
    t_cmd        cmd;
    t_sts        sts;
    logic [31:0] word_out;
    logic [2:0]  status;
    logic        bank_used;
    logic [31:0] write_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_words <= 9'd1;
        end else if (psel && penable && pwrite && paddr[2] == REG_RECORD_WORDS) begin
            r_record_words <= pwdata[8:0];
        end
    end

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_RECORD_WORDS) ? {23'd0, r_record_words} : '0;
    assign rec_len = (int'(r_record_words) > LEN_LIMIT) ? 9'(LEN_LIMIT) : r_record_words;

    dbrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dbrs_datapath #(
        .BANK_WORDS (BANK_WORDS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_rec_len     (rec_len),
        .i_op          (i_s_tuser[1:0]),
        .i_data        (i_s_tdata[31:0]),
        .i_index       (i_s_tdata[40:32]),
        .i_bank_sel    (i_s_tuser[2]),
        .i_last        (i_s_tlast),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_word_out    (word_out),
        .o_status      (status),
        .o_bank_used   (bank_used),
        .o_write_count (write_count)
    );

    assign o_m_tdata = {write_count, word_out};
    assign o_m_tuser = {bank_used, status};

endmodule
